// ===== hw/rtl/amm_pkg.sv =====
// ----------------------------------------------------------------------------
// amm_pkg
// Shared types and constants for the multi-pattern automaton matcher.
// ----------------------------------------------------------------------------
package amm_pkg;

  // field widths of one transaction
  localparam int OP_W        = 2;
  localparam int SYM_W       = 5;
  localparam int IDX_W       = 10;
  localparam int NODE_OUT_W  = 10;
  localparam int COUNT_OUT_W = 32;
  localparam int ERR_W       = 2;

  // stream bus widths
  localparam int S_TDATA_W = 16;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 48;
  localparam int M_TUSER_W = 2;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_BUILD  = 2'd1,
    OP_MATCH  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  // error codes
  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_PHASE = 2'd2
  } err_t;

  // one input item
  typedef struct packed {
    op_t                  op;
    logic [SYM_W-1:0]     symbol;
    logic                 restart;
    logic [IDX_W-1:0]     node_index;
  } item_t;

  // one result item
  typedef struct packed {
    logic [NODE_OUT_W-1:0]  node;
    logic [COUNT_OUT_W-1:0] count;
    err_t                   err;
  } result_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INS_CHK,
    ST_M_RES,
    ST_M_CNT,
    ST_RD_WAIT,
    ST_B_ROOT,
    ST_B_POP,
    ST_B_PGET,
    ST_B_FP,
    ST_B_EDGE,
    ST_B_RES,
    ST_RESP
  } state_t;

endpackage

// ===== hw/rtl/amm_core.sv =====
// ----------------------------------------------------------------------------
// amm_core
// Sequencer and table memories: trie insert, breadth-first failure link
// build, automaton step with transition caching, failure chain counting and count reads.
// ----------------------------------------------------------------------------
module amm_core #(
  parameter int MAX_NODES     = 1024,
  parameter int ALPHABET_SIZE = 26,
  parameter int COUNT_BITS    = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  amm_pkg::item_t   item,
  output logic             res_valid,
  input  logic             res_ready,
  output amm_pkg::result_t res
);

  localparam int IW  = $clog2(MAX_NODES);
  localparam int NW  = $clog2(MAX_NODES + 1);
  localparam int SW  = $clog2(ALPHABET_SIZE);
  localparam int GD  = MAX_NODES * ALPHABET_SIZE;
  localparam int GAW = $clog2(GD);
  localparam logic [NW-1:0]         EMPTY     = NW'(MAX_NODES);
  localparam logic [SW-1:0]         SYM_LAST  = SW'(ALPHABET_SIZE - 1);
  localparam logic [GAW-1:0]        CLR_LAST  = GAW'(GD - 1);
  localparam logic [GAW-1:0]        CNT_CLR_N = GAW'(MAX_NODES);
  localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;

  // goto table address of (node, symbol)
  function automatic logic [GAW-1:0] gaddr(input logic [NW-1:0] node,
                                           input logic [SW-1:0] s);
    gaddr = GAW'(node[IW-1:0]) * GAW'(ALPHABET_SIZE) + GAW'(s);
  endfunction

  // memories
  logic [NW-1:0]         goto_mem  [GD];
  logic [IW-1:0]         fail_mem  [MAX_NODES];
  logic [COUNT_BITS-1:0] cnt_mem   [MAX_NODES];
  logic [IW-1:0]         queue_mem [MAX_NODES];

  logic [GAW-1:0]        g_ra, g_wa;
  logic                  g_we;
  logic [NW-1:0]         g_wd, g_rd;
  logic [IW-1:0]         f_ra, f_wa, f_wd, f_rd;
  logic                  f_we;
  logic [IW-1:0]         c_ra, c_wa;
  logic                  c_we;
  logic [COUNT_BITS-1:0] c_wd, c_rd;
  logic [IW-1:0]         q_ra, q_wa, q_wd, q_rd;
  logic                  q_we;

  // control registers
  amm_pkg::state_t state, state_next;
  logic [GAW-1:0]  clr, clr_next;
  logic [NW-1:0]   nodes_used, nodes_used_next;
  logic [NW-1:0]   cursor, cursor_next;
  logic [NW-1:0]   cur_state, cur_state_next;
  logic            built, built_next;
  logic [NW-1:0]   head, head_next;
  logic [NW-1:0]   tail, tail_next;

  // payload registers
  logic [NW-1:0]    walk, walk_next;
  logic [NW-1:0]    par, par_next;
  logic [NW-1:0]    child, child_next;
  logic [NW-1:0]    fp, fp_next;
  logic [SW-1:0]    csym, csym_next;
  logic [SW-1:0]    sym_r, sym_r_next;
  logic [GAW-1:0]   ga_r, ga_r_next;
  logic             idx_ok, idx_ok_next;
  amm_pkg::result_t res_r, res_next;

  // goto table
  always_ff @(posedge clk) begin
    if (g_we) begin
      goto_mem[g_wa] <= g_wd;
    end
    g_rd <= goto_mem[g_ra];
  end

  // failure links
  always_ff @(posedge clk) begin
    if (f_we) begin
      fail_mem[f_wa] <= f_wd;
    end
    f_rd <= fail_mem[f_ra];
  end

  // visit counts
  always_ff @(posedge clk) begin
    if (c_we) begin
      cnt_mem[c_wa] <= c_wd;
    end
    c_rd <= cnt_mem[c_ra];
  end

  // breadth-first queue
  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[q_wa] <= q_wd;
    end
    q_rd <= queue_mem[q_ra];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= amm_pkg::ST_CLEAR;
      clr        <= '0;
      nodes_used <= NW'(1);
      cursor     <= '0;
      cur_state  <= '0;
      built      <= 1'b0;
      head       <= '0;
      tail       <= '0;
    end else begin
      state      <= state_next;
      clr        <= clr_next;
      nodes_used <= nodes_used_next;
      cursor     <= cursor_next;
      cur_state  <= cur_state_next;
      built      <= built_next;
      head       <= head_next;
      tail       <= tail_next;
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    walk   <= walk_next;
    par    <= par_next;
    child  <= child_next;
    fp     <= fp_next;
    csym   <= csym_next;
    sym_r  <= sym_r_next;
    ga_r   <= ga_r_next;
    idx_ok <= idx_ok_next;
    res_r  <= res_next;
  end

  assign item_ready = (state == amm_pkg::ST_IDLE);
  assign res_valid  = (state == amm_pkg::ST_RESP);
  assign res        = res_r;

  // sequencer
  always_comb begin
    logic [NW-1:0]         base;
    logic [NW-1:0]         r;
    logic [NW-1:0]         f_node;
    logic                  g_empty;
    logic                  sym_valid;
    logic [SW-1:0]         sym_in;
    logic [COUNT_BITS-1:0] sat_inc;

    f_node    = NW'(f_rd);
    g_empty   = (g_rd == EMPTY);
    sym_in    = SW'(item.symbol);
    sym_valid = (int'(item.symbol) < ALPHABET_SIZE);
    sat_inc   = (c_rd == CNT_MAX) ? c_rd : c_rd + 1'b1;
    base      = '0;
    r         = '0;

    state_next      = state;
    clr_next        = clr;
    nodes_used_next = nodes_used;
    cursor_next     = cursor;
    cur_state_next  = cur_state;
    built_next      = built;
    head_next       = head;
    tail_next       = tail;
    walk_next       = walk;
    par_next        = par;
    child_next      = child;
    fp_next         = fp;
    csym_next       = csym;
    sym_r_next      = sym_r;
    ga_r_next       = ga_r;
    idx_ok_next     = idx_ok;
    res_next        = res_r;

    g_ra = '0; g_we = 1'b0; g_wa = '0; g_wd = '0;
    f_ra = '0; f_we = 1'b0; f_wa = '0; f_wd = '0;
    c_ra = '0; c_we = 1'b0; c_wa = '0; c_wd = '0;
    q_ra = '0; q_we = 1'b0; q_wa = '0; q_wd = '0;

    unique case (state)
      // sweep after reset: empty edges, zero counts
      amm_pkg::ST_CLEAR: begin
        g_we = 1'b1;
        g_wa = clr;
        g_wd = EMPTY;
        if (clr < CNT_CLR_N) begin
          c_we = 1'b1;
          c_wa = IW'(clr);
          c_wd = '0;
        end
        if (clr == CLR_LAST) begin
          state_next = amm_pkg::ST_IDLE;
        end else begin
          clr_next = clr + 1'b1;
        end
      end

      // take one transaction and issue its first reads
      amm_pkg::ST_IDLE: begin
        if (item_valid) begin
          sym_r_next = sym_in;
          unique case (item.op)
            amm_pkg::OP_INSERT: begin
              if (built) begin
                res_next   = '{node: '0, count: '0, err: amm_pkg::ERR_PHASE};
                state_next = amm_pkg::ST_RESP;
              end else begin
                base        = item.restart ? '0 : cursor;
                cursor_next = base;
                if (sym_valid) begin
                  g_ra       = gaddr(base, sym_in);
                  ga_r_next  = gaddr(base, sym_in);
                  state_next = amm_pkg::ST_INS_CHK;
                end else begin
                  res_next = '{node: amm_pkg::NODE_OUT_W'(base), count: '0,
                               err: amm_pkg::ERR_OK};
                  state_next = amm_pkg::ST_RESP;
                end
              end
            end
            amm_pkg::OP_BUILD: begin
              if (built) begin
                res_next   = '{node: '0, count: '0, err: amm_pkg::ERR_PHASE};
                state_next = amm_pkg::ST_RESP;
              end else begin
                head_next  = '0;
                tail_next  = '0;
                csym_next  = '0;
                g_ra       = gaddr('0, '0);
                state_next = amm_pkg::ST_B_ROOT;
              end
            end
            amm_pkg::OP_MATCH: begin
              if (!built) begin
                res_next = '{node: amm_pkg::NODE_OUT_W'(cur_state), count: '0,
                             err: amm_pkg::ERR_PHASE};
                state_next = amm_pkg::ST_RESP;
              end else begin
                base           = item.restart ? '0 : cur_state;
                cur_state_next = base;
                if (sym_valid) begin
                  g_ra       = gaddr(base, sym_in);
                  ga_r_next  = gaddr(base, sym_in);
                  f_ra       = base[IW-1:0];
                  walk_next  = base;
                  state_next = amm_pkg::ST_M_RES;
                end else begin
                  res_next = '{node: amm_pkg::NODE_OUT_W'(base), count: '0,
                               err: amm_pkg::ERR_OK};
                  state_next = amm_pkg::ST_RESP;
                end
              end
            end
            amm_pkg::OP_READ: begin
              c_ra        = IW'(item.node_index);
              idx_ok_next = (int'(item.node_index) < MAX_NODES);
              state_next  = amm_pkg::ST_RD_WAIT;
            end
          endcase
        end
      end

      // follow or create the trie edge
      amm_pkg::ST_INS_CHK: begin
        if (g_empty) begin
          if (nodes_used == NW'(MAX_NODES)) begin
            res_next = '{node: amm_pkg::NODE_OUT_W'(cursor), count: '0,
                         err: amm_pkg::ERR_FULL};
          end else begin
            g_we            = 1'b1;
            g_wa            = ga_r;
            g_wd            = nodes_used;
            cursor_next     = nodes_used;
            nodes_used_next = nodes_used + 1'b1;
            res_next = '{node: amm_pkg::NODE_OUT_W'(nodes_used), count: '0,
                         err: amm_pkg::ERR_OK};
          end
        end else begin
          cursor_next = g_rd;
          res_next    = '{node: amm_pkg::NODE_OUT_W'(g_rd), count: '0,
                          err: amm_pkg::ERR_OK};
        end
        state_next = amm_pkg::ST_RESP;
      end

      // resolve the transition through failure links, then cache it
      amm_pkg::ST_M_RES: begin
        if (!g_empty || walk == '0) begin
          r              = g_empty ? '0 : g_rd;
          g_we           = 1'b1;
          g_wa           = ga_r;
          g_wd           = r;
          cur_state_next = r;
          if (r == '0) begin
            res_next   = '{node: '0, count: '0, err: amm_pkg::ERR_OK};
            state_next = amm_pkg::ST_RESP;
          end else begin
            walk_next  = r;
            c_ra       = r[IW-1:0];
            f_ra       = r[IW-1:0];
            state_next = amm_pkg::ST_M_CNT;
          end
        end else begin
          walk_next = f_node;
          g_ra      = gaddr(f_node, sym_r);
          f_ra      = f_rd;
        end
      end

      // bump counts down the failure chain, one node a cycle
      amm_pkg::ST_M_CNT: begin
        c_we = 1'b1;
        c_wa = walk[IW-1:0];
        c_wd = sat_inc;
        if (f_node == '0) begin
          res_next = '{node: amm_pkg::NODE_OUT_W'(cur_state), count: '0,
                       err: amm_pkg::ERR_OK};
          state_next = amm_pkg::ST_RESP;
        end else begin
          walk_next = f_node;
          c_ra      = f_rd;
          f_ra      = f_rd;
        end
      end

      // count read returns
      amm_pkg::ST_RD_WAIT: begin
        res_next = '{node: '0,
                     count: idx_ok ? amm_pkg::COUNT_OUT_W'(c_rd) : '0,
                     err: amm_pkg::ERR_OK};
        state_next = amm_pkg::ST_RESP;
      end

      // root edges: fill missing ones, queue the children
      amm_pkg::ST_B_ROOT: begin
        if (g_empty) begin
          g_we = 1'b1;
          g_wa = gaddr('0, csym);
          g_wd = '0;
        end else begin
          f_we = 1'b1;
          f_wa = g_rd[IW-1:0];
          f_wd = '0;
          if (tail != NW'(MAX_NODES)) begin
            q_we      = 1'b1;
            q_wa      = tail[IW-1:0];
            q_wd      = g_rd[IW-1:0];
            tail_next = tail + 1'b1;
          end
        end
        if (csym == SYM_LAST) begin
          state_next = amm_pkg::ST_B_POP;
        end else begin
          csym_next = csym + 1'b1;
          g_ra      = gaddr('0, csym + 1'b1);
        end
      end

      // next node from the queue
      amm_pkg::ST_B_POP: begin
        if (head == tail) begin
          built_next = 1'b1;
          res_next   = '{node: '0, count: '0, err: amm_pkg::ERR_OK};
          state_next = amm_pkg::ST_RESP;
        end else begin
          q_ra       = head[IW-1:0];
          head_next  = head + 1'b1;
          state_next = amm_pkg::ST_B_PGET;
        end
      end

      amm_pkg::ST_B_PGET: begin
        par_next   = NW'(q_rd);
        f_ra       = q_rd;
        state_next = amm_pkg::ST_B_FP;
      end

      amm_pkg::ST_B_FP: begin
        fp_next    = f_node;
        csym_next  = '0;
        g_ra       = gaddr(par, '0);
        state_next = amm_pkg::ST_B_EDGE;
      end

      // scan the children of the popped node
      amm_pkg::ST_B_EDGE: begin
        if (g_empty) begin
          if (csym == SYM_LAST) begin
            state_next = amm_pkg::ST_B_POP;
          end else begin
            csym_next = csym + 1'b1;
            g_ra      = gaddr(par, csym + 1'b1);
          end
        end else begin
          child_next = g_rd;
          if (tail != NW'(MAX_NODES)) begin
            q_we      = 1'b1;
            q_wa      = tail[IW-1:0];
            q_wd      = g_rd[IW-1:0];
            tail_next = tail + 1'b1;
          end
          walk_next  = fp;
          g_ra       = gaddr(fp, csym);
          f_ra       = fp[IW-1:0];
          state_next = amm_pkg::ST_B_RES;
        end
      end

      // failure link of the child
      amm_pkg::ST_B_RES: begin
        if (!g_empty || walk == '0) begin
          f_we = 1'b1;
          f_wa = child[IW-1:0];
          f_wd = g_empty ? '0 : g_rd[IW-1:0];
          if (csym == SYM_LAST) begin
            state_next = amm_pkg::ST_B_POP;
          end else begin
            csym_next  = csym + 1'b1;
            g_ra       = gaddr(par, csym + 1'b1);
            state_next = amm_pkg::ST_B_EDGE;
          end
        end else begin
          walk_next = f_node;
          g_ra      = gaddr(f_node, csym);
          f_ra      = f_rd;
        end
      end

      // hand the result to the output register
      amm_pkg::ST_RESP: begin
        if (res_ready) begin
          state_next = amm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = amm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/multi_pattern_automaton_matcher_top.sv =====
// ----------------------------------------------------------------------------
// multi_pattern_automaton_matcher_top
// Multi-pattern matcher with a trie, failure links and per-node visit counts.
//
//   channel  dir  payload                                     handshake
//   s_*      in   tdata: symbol, node_index; tuser: op, restart  tvalid/tready
//   m_*      out  tdata: node_out, count_out; tuser: error       tvalid/tready
//
// After reset a clearing pass empties the goto table; no transaction is
// taken until it ends.
// An insert goes through a check state and a read through a read-wait state
// to the response; a phase error or an out-of-range symbol goes straight there.
// A match step follows failure links, then walks the failure chain; a build
// scans every symbol of each queued node and resolves each child's failure link.
// The table memories take one read and one write a cycle.
// The output register lets the next transaction in while a result is stalled.
// ----------------------------------------------------------------------------
module multi_pattern_automaton_matcher_top #(
  parameter int MAX_NODES     = 1024,
  parameter int ALPHABET_SIZE = 26,
  parameter int COUNT_BITS    = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [amm_pkg::S_TDATA_W-1:0]   s_tdata,  // symbol, node_index, pad
  input  logic [amm_pkg::S_TUSER_W-1:0]   s_tuser,  // op, restart
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [amm_pkg::M_TDATA_W-1:0]   m_tdata,  // node_out, count_out, pad
  output logic [amm_pkg::M_TUSER_W-1:0]   m_tuser   // error
);

  localparam int PAD_W = amm_pkg::M_TDATA_W - amm_pkg::NODE_OUT_W
                         - amm_pkg::COUNT_OUT_W;

  amm_pkg::item_t   item;
  amm_pkg::result_t res;
  amm_pkg::result_t out_r;
  logic             res_valid;
  logic             res_ready;

  // unpack the input transaction
  assign item.op         = amm_pkg::op_t'(s_tuser[amm_pkg::OP_W-1:0]);
  assign item.restart    = s_tuser[amm_pkg::OP_W];
  assign item.symbol     = s_tdata[amm_pkg::SYM_W-1:0];
  assign item.node_index = s_tdata[amm_pkg::SYM_W +: amm_pkg::IDX_W];

  amm_core #(
    .MAX_NODES     (MAX_NODES),
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .COUNT_BITS    (COUNT_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (s_tvalid),
    .item_ready (s_tready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // output register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_r.count, out_r.node};
  assign m_tuser = out_r.err;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-pattern automaton matcher. It builds a
// trie from short overlapping patterns and random inserts, builds failure
// links and runs text symbols and count reads. Each accepted transaction is
// predicted by a local automaton model, and every result is compared field
// by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int NODES     = 1024;
  localparam int ALPH      = 26;
  localparam int EMPTY     = NODES;
  localparam int WDOG_MAX  = 200000;
  localparam int HOLD_LEN  = 400;
  localparam int HOLD_AT   = 400;

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [amm_pkg::S_TDATA_W-1:0] s_tdata;   // symbol, node_index, pad
  logic [amm_pkg::S_TUSER_W-1:0] s_tuser;   // op, restart
  logic                          m_tvalid;
  logic                          m_tready;
  logic [amm_pkg::M_TDATA_W-1:0] m_tdata;   // node_out, count_out, pad
  logic [amm_pkg::M_TUSER_W-1:0] m_tuser;   // error

  multi_pattern_automaton_matcher_top u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // pending stimulus and expected results
  amm_pkg::item_t   pending_items[$];
  amm_pkg::item_t   cur_item;
  amm_pkg::result_t expected_results[$];
  int      total_items;
  int      sent_cnt;
  int      err_cnt;
  int      idle_cnt;
  int      hold_left;
  bit      hold_done;

  // automaton model state
  int unsigned trie_edge[NODES*ALPH];
  int unsigned fail_to[NODES];
  longint unsigned visits[NODES];
  int unsigned node_total;
  int unsigned ins_pos;
  int unsigned text_pos;
  bit          linked;

  function automatic int unsigned follow_fail(int unsigned n, int unsigned c);
    int unsigned p;
    int unsigned g;
    p = n;
    g = 0;
    while (trie_edge[p*ALPH+c] == EMPTY && p != 0 && g < NODES) begin
      p = fail_to[p];
      g++;
    end
    if (trie_edge[p*ALPH+c] == EMPTY) return 0;
    return trie_edge[p*ALPH+c];
  endfunction

  function automatic void link_trie();
    int unsigned bfs[$];
    int unsigned p;
    int unsigned u;
    for (int c = 0; c < ALPH; c++) begin
      u = trie_edge[c];
      if (u != EMPTY) begin
        fail_to[u] = 0;
        bfs.push_back(u);
      end else begin
        trie_edge[c] = 0;
      end
    end
    while (bfs.size() > 0) begin
      p = bfs.pop_front();
      for (int c = 0; c < ALPH; c++) begin
        u = trie_edge[p*ALPH+c];
        if (u == EMPTY) continue;
        bfs.push_back(u);
        fail_to[u] = follow_fail(fail_to[p], c);
      end
    end
  endfunction

  // advance the model by one transaction and return its result
  function automatic amm_pkg::result_t step_automaton(amm_pkg::item_t it);
    amm_pkg::result_t r;
    int unsigned nx;
    int unsigned v;
    int unsigned g;
    r.node  = '0;
    r.count = '0;
    r.err   = amm_pkg::ERR_OK;
    case (it.op)
      amm_pkg::OP_INSERT: begin
        if (linked) begin
          r.err = amm_pkg::ERR_PHASE;
        end else begin
          if (it.restart) ins_pos = 0;
          if (it.symbol < ALPH) begin
            nx = trie_edge[ins_pos*ALPH+it.symbol];
            if (nx == EMPTY) begin
              if (node_total >= NODES) begin
                r.err = amm_pkg::ERR_FULL;
              end else begin
                nx = node_total++;
                trie_edge[ins_pos*ALPH+it.symbol] = nx;
                ins_pos = nx;
              end
            end else begin
              ins_pos = nx;
            end
          end
          r.node = ins_pos;
        end
      end
      amm_pkg::OP_BUILD: begin
        if (linked) r.err = amm_pkg::ERR_PHASE;
        else begin
          link_trie();
          linked = 1;
        end
      end
      amm_pkg::OP_MATCH: begin
        if (!linked) begin
          r.err  = amm_pkg::ERR_PHASE;
          r.node = text_pos;
        end else begin
          if (it.restart) text_pos = 0;
          if (it.symbol < ALPH) begin
            v = text_pos;
            if (trie_edge[v*ALPH+it.symbol] == EMPTY)
              trie_edge[v*ALPH+it.symbol] = follow_fail(v, it.symbol);
            v = trie_edge[v*ALPH+it.symbol];
            text_pos = v;
            g = 0;
            while (v != 0 && g < NODES) begin
              if (visits[v] < 64'hFFFF_FFFF) visits[v]++;
              v = fail_to[v];
              g++;
            end
          end
          r.node = text_pos;
        end
      end
      default: r.count = visits[it.node_index];
    endcase
    return r;
  endfunction

  function automatic amm_pkg::item_t mk(amm_pkg::op_t op, int sym, bit rs, int idx);
    amm_pkg::item_t it;
    it.op         = op;
    it.symbol     = sym;
    it.restart    = rs;
    it.node_index = idx;
    return it;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // idle percentage per phase: sender then receiver
  function automatic int idle_pct(bit rx);
    int ph;
    ph = (total_items == 0) ? 0 : sent_cnt * 3 / total_items;
    if (ph == 0) return rx ? 69 : 23;
    if (ph == 1) return rx ? 23 : 69;
    return 0;
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(step_automaton(cur_item));
        sent_cnt++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct(0)) begin
          cur_item = pending_items.pop_front();
          s_tdata  <= {1'b0, cur_item.node_index, cur_item.symbol};
          s_tuser  <= {cur_item.restart, cur_item.op};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!hold_done && sent_cnt >= HOLD_AT) begin
      hold_done = 1;
      hold_left = HOLD_LEN;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= idle_pct(1));
    end
  end

  // monitor
  always @(posedge clk) begin
    amm_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result transaction", m_tdata[9:0], 0);
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[9:0] !== want.node) report_mismatch("node_out", m_tdata[9:0], want.node);
        if (m_tdata[41:10] !== want.count)
          report_mismatch("count_out", m_tdata[41:10], want.count);
        if (m_tuser !== want.err) report_mismatch("error", m_tuser, want.err);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WDOG_MAX) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // stimulus and end of run
  initial begin
    int len;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = '0;
    m_tready   = 1'b0;
    sent_cnt   = 0;
    err_cnt    = 0;
    idle_cnt   = 0;
    hold_left  = 0;
    hold_done  = 0;
    foreach (trie_edge[i]) trie_edge[i] = EMPTY;
    foreach (fail_to[i]) fail_to[i] = 0;
    foreach (visits[i]) visits[i] = 0;
    node_total = 1;
    ins_pos    = 0;
    text_pos   = 0;
    linked     = 0;

    // directed: phase errors, out-of-range symbols, restart, read extremes
    pending_items.push_back(mk(amm_pkg::OP_READ, 0, 1, 1023));
    pending_items.push_back(mk(amm_pkg::OP_MATCH, 3, 1, 0));
    pending_items.push_back(mk(amm_pkg::OP_INSERT, 0, 1, 1023));
    pending_items.push_back(mk(amm_pkg::OP_INSERT, 31, 0, 0));
    pending_items.push_back(mk(amm_pkg::OP_INSERT, 1, 0, 512));
    pending_items.push_back(mk(amm_pkg::OP_INSERT, 26, 1, 0));
    pending_items.push_back(mk(amm_pkg::OP_INSERT, 25, 0, 0));
    pending_items.push_back(mk(amm_pkg::OP_INSERT, 1, 1, 0));

    // short overlapping patterns over a tiny alphabet give deep failure chains
    for (int p = 0; p < 12; p++) begin
      len = $urandom_range(2, 6);
      for (int k = 0; k < len; k++)
        pending_items.push_back(mk(amm_pkg::OP_INSERT, $urandom_range(2), k == 0,
                                   $urandom_range(1023)));
    end

    // random inserts, then some with out-of-range symbols
    for (int k = 0; k < 200; k++)
      pending_items.push_back(mk(amm_pkg::OP_INSERT, $urandom_range(25),
                                 ($urandom_range(7) == 0), $urandom_range(1023)));
    for (int k = 0; k < 40; k++)
      pending_items.push_back(mk(amm_pkg::OP_INSERT, $urandom_range(31), 0,
                                 $urandom_range(1023)));
    pending_items.push_back(mk(amm_pkg::OP_INSERT, 0, 1, 0));

    // build, second build, insert after build, out-of-range match
    pending_items.push_back(mk(amm_pkg::OP_BUILD, 0, 0, 0));
    pending_items.push_back(mk(amm_pkg::OP_BUILD, 31, 1, 1023));
    pending_items.push_back(mk(amm_pkg::OP_INSERT, 2, 1, 0));
    pending_items.push_back(mk(amm_pkg::OP_MATCH, 31, 1, 0));

    // text symbols and reads
    for (int k = 0; k < 300; k++) begin
      if ($urandom_range(3) == 0)
        pending_items.push_back(mk(amm_pkg::OP_READ, $urandom_range(31), $urandom_range(1),
                                   $urandom_range(1) ? $urandom_range(60) : $urandom_range(1023)));
      else
        pending_items.push_back(mk(amm_pkg::OP_MATCH,
                                   $urandom_range(3) ? $urandom_range(2) : $urandom_range(31),
                                   ($urandom_range(19) == 0), $urandom_range(1023)));
    end
    for (int k = 0; k < 24; k++)
      pending_items.push_back(mk(amm_pkg::OP_READ, 0, 0, k));
    total_items = pending_items.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    wait (sent_cnt == total_items && expected_results.size() == 0);
    repeat (100) @(posedge clk);
    if (err_cnt == 0 && expected_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/amm_pkg.sv
hw/rtl/amm_core.sv
hw/rtl/multi_pattern_automaton_matcher_top.sv
tb/tb_top.sv
